### hw/rtl/st2ptw_pkg.sv
// Shared types, codes and constants of the stage-2 page table walker.
package st2ptw_pkg;

    localparam int PHYS_ADDR_BITS_DEFAULT = 48;

    localparam int GUEST_ADDR_W  = 56;
    localparam int DESC_W        = 64;
    localparam int OUT_ADDR_W    = 48;
    localparam int SIZE_OFFSET_W = 6;
    localparam int PAGE_INDEX_W  = 9;
    localparam int LEVEL_W       = 2;
    localparam int KIND_W        = 3;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 48;
    localparam int IN_TDATA_W    = 120;
    localparam int OUT_TDATA_W   = 120;

    localparam logic [KIND_W-1:0] KIND_READ       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LEAF       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FAULT      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RANGE      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_UNEXPECTED = 3'd4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DESC  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_OFFSET = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_BASE  = 1'b1;

    localparam logic [SIZE_OFFSET_W-1:0] SIZE_OFFSET_RESET = 6'd32;
    localparam logic [LEVEL_W-1:0]       START_LEVEL       = 2'd2;
    localparam logic [LEVEL_W-1:0]       LAST_LEVEL        = 2'd3;

    typedef struct packed {
        logic                    pending;
        logic [LEVEL_W-1:0]      level;
        logic [PAGE_INDEX_W-1:0] page_index;
    } walk_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [OUT_ADDR_W-1:0] read_address;
        logic [DESC_W-1:0]     leaf_descriptor;
        logic [LEVEL_W-1:0]    walk_level;
    } walk_result_t;

endpackage

### hw/rtl/st2ptw_step.sv
// Decode of one walker item: the result and the next walk state.
module st2ptw_step #(
    parameter int PHYS_ADDR_BITS = st2ptw_pkg::PHYS_ADDR_BITS_DEFAULT
) (
    input  logic                                   operation,
    input  logic [st2ptw_pkg::GUEST_ADDR_W-1:0]    guest_address,
    input  logic [st2ptw_pkg::DESC_W-1:0]          descriptor_data,
    input  logic [st2ptw_pkg::SIZE_OFFSET_W-1:0]   input_size_offset,
    input  logic [st2ptw_pkg::OUT_ADDR_W-1:0]      table_base_address,
    input  st2ptw_pkg::walk_state_t                state_cur,
    output st2ptw_pkg::walk_state_t                state_upd,
    output st2ptw_pkg::walk_result_t               result
);

    localparam logic [st2ptw_pkg::DESC_W-1:0] PhysMask =
        (64'd1 << PHYS_ADDR_BITS) - 64'd1;

    function automatic logic [63:0] low_mask(input logic [6:0] n);
        logic [63:0] m;
        if (n >= 7'd64)
        begin
            m = '1;
        end
        else
        begin
            m = (64'd1 << n) - 64'd1;
        end
        return m;
    endfunction

    logic [6:0]                          ias;
    logic [6:0]                          tsize;
    logic [63:0]                         range_mask;
    logic [63:0]                         base_mask;
    logic                                out_of_range;
    logic [st2ptw_pkg::OUT_ADDR_W-1:0]   base_aligned;
    logic [st2ptw_pkg::OUT_ADDR_W-1:0]   l2_address;
    logic [st2ptw_pkg::DESC_W-1:0]       next_table;
    logic [st2ptw_pkg::OUT_ADDR_W-1:0]   l3_address;
    logic [st2ptw_pkg::LEVEL_W-1:0]      level;
    logic                                desc_valid;
    logic                                desc_table;

    assign ias          = 7'd64 - {1'b0, input_size_offset};
    assign tsize        = (ias > 7'd18) ? (ias - 7'd18) : 7'd0;
    assign range_mask   = low_mask(ias);
    assign base_mask    = low_mask(tsize);
    assign out_of_range = (ias < 7'd56)
                          && ((guest_address & ~range_mask[st2ptw_pkg::GUEST_ADDR_W-1:0]) != '0);
    assign base_aligned = table_base_address & ~base_mask[st2ptw_pkg::OUT_ADDR_W-1:0];
    // Once the range check passes, the address bits above the input size are zero.
    assign l2_address   = base_aligned | {10'd0, guest_address[55:21], 3'b000};
    assign next_table   = descriptor_data & PhysMask;
    assign l3_address   = {next_table[47:12], state_cur.page_index, 3'b000};
    assign level        = (state_cur.level == st2ptw_pkg::LAST_LEVEL)
                          ? st2ptw_pkg::LAST_LEVEL : st2ptw_pkg::START_LEVEL;
    assign desc_valid   = descriptor_data[0];
    assign desc_table   = descriptor_data[1];

    always_comb
    begin
        state_upd = state_cur;
        result    = '0;
        if (operation == st2ptw_pkg::OP_START)
        begin
            if (out_of_range)
            begin
                state_upd.pending = 1'b0;
                state_upd.level   = st2ptw_pkg::START_LEVEL;
                result.kind       = st2ptw_pkg::KIND_RANGE;
            end
            else
            begin
                state_upd.pending    = 1'b1;
                state_upd.level      = st2ptw_pkg::START_LEVEL;
                state_upd.page_index = guest_address[20:12];
                result.kind          = st2ptw_pkg::KIND_READ;
                result.read_address  = l2_address;
                result.walk_level    = st2ptw_pkg::START_LEVEL;
            end
        end
        else if (!state_cur.pending)
        begin
            result.kind = st2ptw_pkg::KIND_UNEXPECTED;
        end
        else if (!desc_valid || (level == st2ptw_pkg::LAST_LEVEL && !desc_table))
        begin
            state_upd.pending = 1'b0;
            state_upd.level   = st2ptw_pkg::START_LEVEL;
            result.kind       = st2ptw_pkg::KIND_FAULT;
            result.walk_level = level;
        end
        else if (level == st2ptw_pkg::LAST_LEVEL || !desc_table)
        begin
            state_upd.pending      = 1'b0;
            state_upd.level        = st2ptw_pkg::START_LEVEL;
            result.kind            = st2ptw_pkg::KIND_LEAF;
            result.leaf_descriptor = descriptor_data;
            result.walk_level      = level;
        end
        else
        begin
            state_upd.level     = st2ptw_pkg::LAST_LEVEL;
            result.kind         = st2ptw_pkg::KIND_READ;
            result.read_address = l3_address;
            result.walk_level   = st2ptw_pkg::LAST_LEVEL;
        end
    end

endmodule

### hw/rtl/stage2_page_table_walker.sv
// Stage-2 page table walker top level with stream ports and configuration registers.
//
// The walker takes one item per clock cycle while the output side keeps taking results,
// and returns exactly one result item for each, in order. An item passes through the
// input register and then the result register, with the whole decode (range check,
// level-2 or level-3 address, descriptor classification) done by a single step between
// them. The walk state is updated as an item passes from the input register to the
// result register, so a descriptor item that follows a start item directly sees the new
// walk. While an earlier result waits for the output side to take it, an empty input
// register can still let the next item in.
module stage2_page_table_walker #(
    parameter int PHYS_ADDR_BITS = st2ptw_pkg::PHYS_ADDR_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [st2ptw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [st2ptw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // guest_address [55:0], descriptor_data [119:56]
    input  logic [st2ptw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation [0]
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // read_address [47:0], leaf_descriptor [111:48], walk_level [113:112], zero above
    output logic [st2ptw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // result_kind [2:0]
    output logic [st2ptw_pkg::KIND_W-1:0]         m_axis_tuser
);

    logic [st2ptw_pkg::SIZE_OFFSET_W-1:0] input_size_offset_reg;
    logic [st2ptw_pkg::OUT_ADDR_W-1:0]    table_base_address_reg;

    logic                                 in_valid_reg;
    logic                                 in_op_reg;
    logic [st2ptw_pkg::GUEST_ADDR_W-1:0]  in_addr_reg;
    logic [st2ptw_pkg::DESC_W-1:0]        in_desc_reg;

    st2ptw_pkg::walk_state_t              state_reg;
    st2ptw_pkg::walk_state_t              state_next;
    st2ptw_pkg::walk_result_t             result_next;

    logic                                 out_valid_reg;
    st2ptw_pkg::walk_result_t             out_result_reg;

    logic                                 advance;
    logic                                 take_in;
    logic                                 move;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;
    assign move          = in_valid_reg && advance;

    st2ptw_step #(
        .PHYS_ADDR_BITS(PHYS_ADDR_BITS)
    ) u_step (
        .operation          (in_op_reg),
        .guest_address      (in_addr_reg),
        .descriptor_data    (in_desc_reg),
        .input_size_offset  (input_size_offset_reg),
        .table_base_address (table_base_address_reg),
        .state_cur          (state_reg),
        .state_upd          (state_next),
        .result             (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_size_offset_reg  <= st2ptw_pkg::SIZE_OFFSET_RESET;
            table_base_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                st2ptw_pkg::REG_SIZE_OFFSET:
                begin
                    input_size_offset_reg <= cfg_data[st2ptw_pkg::SIZE_OFFSET_W-1:0];
                end
                st2ptw_pkg::REG_TABLE_BASE:
                begin
                    table_base_address_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{pending: 1'b0, level: st2ptw_pkg::START_LEVEL, page_index: '0};
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_op_reg   <= s_axis_tuser;
            in_addr_reg <= s_axis_tdata[55:0];
            in_desc_reg <= s_axis_tdata[119:56];
        end
        if (move)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_result_reg.kind;
    assign m_axis_tdata  = {6'd0, out_result_reg.walk_level, out_result_reg.leaf_descriptor,
                            out_result_reg.read_address};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.level == st2ptw_pkg::LAST_LEVEL |-> state_reg.pending)
        else $error("Walk at the last level without a walk pending.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != st2ptw_pkg::KIND_LEAF |-> m_axis_tdata[111:48] == '0)
        else $error("Leaf descriptor set on a result that is not a leaf.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == st2ptw_pkg::KIND_RANGE
                          || m_axis_tuser == st2ptw_pkg::KIND_UNEXPECTED)
        |-> m_axis_tdata[113:112] == '0)
        else $error("Level reported on an out-of-range or unexpected result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        move && in_op_reg == st2ptw_pkg::OP_DESC && !state_reg.pending
        |=> m_axis_tuser == st2ptw_pkg::KIND_UNEXPECTED && $stable(state_reg))
        else $error("Descriptor while idle did not give an unexpected result.");
`endif

endmodule

### dv/stage2_page_table_walker_checker.sv
`timescale 1ns / 100ps
// Checker for the stage-2 walker: predicts each result item from the accepted items and compares.
module stage2_page_table_walker_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [st2ptw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [st2ptw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    // guest_address [55:0], descriptor_data [119:56]
    input  logic [st2ptw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation [0]
    input  logic                                  s_axis_tuser,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // read_address [47:0], leaf_descriptor [111:48], walk_level [113:112], zero above
    input  logic [st2ptw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // result_kind [2:0]
    input  logic [st2ptw_pkg::KIND_W-1:0]         m_axis_tuser,
    output int                                    mismatches,
    output int                                    outstanding,
    output int                                    results_checked,
    output int                                    leaves_seen,
    output int                                    faults_seen
);

    logic [st2ptw_pkg::SIZE_OFFSET_W-1:0] size_offset_copy;
    logic [st2ptw_pkg::OUT_ADDR_W-1:0]    base_copy;
    logic                                 walk_busy;
    logic [st2ptw_pkg::LEVEL_W-1:0]       walk_depth;
    logic [st2ptw_pkg::PAGE_INDEX_W-1:0]  page_idx;

    st2ptw_pkg::walk_result_t expected_walk_results[$];

    function automatic logic [63:0] low_bits(input int unsigned bits);
        return (bits >= 64) ? {64{1'b1}} : ((64'h1 << bits) - 64'h1);
    endfunction

    // Advances the walk by one item and returns the result item it should give.
    function automatic st2ptw_pkg::walk_result_t translate_step(
        input logic                                op,
        input logic [st2ptw_pkg::GUEST_ADDR_W-1:0] ga,
        input logic [st2ptw_pkg::DESC_W-1:0]       dd);
        st2ptw_pkg::walk_result_t       r;
        int unsigned                    ias;
        int unsigned                    tsize;
        logic [63:0]                    ga_w;
        logic [63:0]                    aligned_base;
        logic [63:0]                    l2_index;
        logic [st2ptw_pkg::LEVEL_W-1:0] lvl;
        r = '0;
        ias = 64 - size_offset_copy;
        ga_w = {8'h0, ga};
        if (op == st2ptw_pkg::OP_START)
        begin
            if (ias < 56 && (ga_w >> ias) != 64'h0)
            begin
                walk_busy = 1'b0;
                walk_depth = st2ptw_pkg::START_LEVEL;
                r.kind = st2ptw_pkg::KIND_RANGE;
            end
            else
            begin
                tsize = (ias > 18) ? ias - 18 : 0;
                aligned_base = {16'h0, base_copy} & ~low_bits(tsize);
                l2_index = (ias > 21) ? ((ga_w & low_bits(ias)) >> 21) : 64'h0;
                r.kind = st2ptw_pkg::KIND_READ;
                r.read_address = st2ptw_pkg::OUT_ADDR_W'(aligned_base | (l2_index << 3));
                r.walk_level = st2ptw_pkg::START_LEVEL;
                page_idx = ga[20:12];
                walk_depth = st2ptw_pkg::START_LEVEL;
                walk_busy = 1'b1;
            end
        end
        else
        begin
            lvl = (walk_depth == st2ptw_pkg::LAST_LEVEL)
                  ? st2ptw_pkg::LAST_LEVEL : st2ptw_pkg::START_LEVEL;
            if (!walk_busy)
            begin
                r.kind = st2ptw_pkg::KIND_UNEXPECTED;
            end
            else if (!dd[0] || (lvl == st2ptw_pkg::LAST_LEVEL && !dd[1]))
            begin
                r.kind = st2ptw_pkg::KIND_FAULT;
                r.walk_level = lvl;
                walk_busy = 1'b0;
                walk_depth = st2ptw_pkg::START_LEVEL;
            end
            else if (lvl == st2ptw_pkg::LAST_LEVEL || !dd[1])
            begin
                r.kind = st2ptw_pkg::KIND_LEAF;
                r.leaf_descriptor = dd;
                r.walk_level = lvl;
                walk_busy = 1'b0;
                walk_depth = st2ptw_pkg::START_LEVEL;
            end
            else
            begin
                r.kind = st2ptw_pkg::KIND_READ;
                r.read_address = {dd[st2ptw_pkg::OUT_ADDR_W-1:12], page_idx, 3'b000};
                r.walk_level = st2ptw_pkg::LAST_LEVEL;
                walk_depth = st2ptw_pkg::LAST_LEVEL;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        st2ptw_pkg::walk_result_t want;
        if (!rst_n)
        begin
            size_offset_copy = st2ptw_pkg::SIZE_OFFSET_RESET;
            base_copy = '0;
            walk_busy = 1'b0;
            walk_depth = st2ptw_pkg::START_LEVEL;
            page_idx = '0;
            expected_walk_results.delete();
            mismatches = 0;
            results_checked = 0;
            leaves_seen = 0;
            faults_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == st2ptw_pkg::REG_SIZE_OFFSET)
                    size_offset_copy = cfg_data[st2ptw_pkg::SIZE_OFFSET_W-1:0];
                else if (cfg_index == st2ptw_pkg::REG_TABLE_BASE)
                    base_copy = cfg_data[st2ptw_pkg::OUT_ADDR_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_walk_results.push_back(translate_step(s_axis_tuser,
                    s_axis_tdata[st2ptw_pkg::GUEST_ADDR_W-1:0],
                    s_axis_tdata[st2ptw_pkg::GUEST_ADDR_W +: st2ptw_pkg::DESC_W]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_walk_results.size() == 0)
                begin
                    $error("result item with none expected: kind %0d", m_axis_tuser);
                    mismatches++;
                end
                else
                begin
                    want = expected_walk_results.pop_front();
                    results_checked++;
                    if (m_axis_tuser == st2ptw_pkg::KIND_LEAF)
                        leaves_seen++;
                    if (m_axis_tuser == st2ptw_pkg::KIND_FAULT)
                        faults_seen++;
                    if (m_axis_tuser !== want.kind)
                    begin
                        $error("result_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata[47:0] !== want.read_address)
                    begin
                        $error("read_address: expected %h, actual %h",
                               want.read_address, m_axis_tdata[47:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[111:48] !== want.leaf_descriptor)
                    begin
                        $error("leaf_descriptor: expected %h, actual %h",
                               want.leaf_descriptor, m_axis_tdata[111:48]);
                        mismatches++;
                    end
                    if (m_axis_tdata[113:112] !== want.walk_level)
                    begin
                        $error("walk_level: expected %0d, actual %0d",
                               want.walk_level, m_axis_tdata[113:112]);
                        mismatches++;
                    end
                    if (m_axis_tdata[119:114] !== 6'h0)
                    begin
                        $error("tdata padding: expected %h, actual %h",
                               6'h0, m_axis_tdata[119:114]);
                        mismatches++;
                    end
                end
            end
            outstanding <= expected_walk_results.size();
        end
    end

endmodule

### dv/stage2_page_table_walker_tb.sv
`timescale 1ns / 100ps
// Testbench top for the stage-2 walker: clock, reset, register settings, item stimulus and verdict.
module stage2_page_table_walker_tb;

    localparam int CYCLE_LIMIT = 200000;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  cfg_we;
    logic [st2ptw_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [st2ptw_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                  s_axis_tvalid;
    logic                                  s_axis_tready;
    logic [st2ptw_pkg::IN_TDATA_W-1:0]     s_axis_tdata;
    logic                                  s_axis_tuser;
    logic                                  m_axis_tvalid;
    logic                                  m_axis_tready;
    logic [st2ptw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic [st2ptw_pkg::KIND_W-1:0]         m_axis_tuser;

    int  mismatches;
    int  outstanding;
    int  results_checked;
    int  leaves_seen;
    int  faults_seen;
    int  items_accepted = 0;
    int  settings_used = 0;
    int  cycles = 0;
    bit  steady = 1'b0;

    stage2_page_table_walker uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    stage2_page_table_walker_checker walk_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .leaves_seen     (leaves_seen),
        .faults_seen     (faults_seen)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= 29);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL stage2_page_table_walker");
            $finish;
        end
    end

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [st2ptw_pkg::GUEST_ADDR_W-1:0] guest_in_range(
        input int unsigned ias);
        logic [63:0] r;
        int unsigned pick;
        r = random_word();
        pick = $urandom_range(99);
        if (pick < 10)
            r = {64{1'b1}};
        else if (pick < 15)
            r = 64'h0;
        if (ias < 56)
            r = r & ((64'h1 << ias) - 64'h1);
        return r[st2ptw_pkg::GUEST_ADDR_W-1:0];
    endfunction

    // Mostly valid table or page entries so that walks reach level 3.
    function automatic logic [st2ptw_pkg::DESC_W-1:0] random_descriptor();
        logic [63:0] r;
        int unsigned pick;
        r = random_word();
        pick = $urandom_range(99);
        if (pick < 15)
            r[0] = 1'b0;
        else if (pick < 40)
            r[1:0] = 2'b01;
        else
            r[1:0] = 2'b11;
        return r;
    endfunction

    task automatic issue_item(input logic op,
                              input logic [st2ptw_pkg::GUEST_ADDR_W-1:0] ga,
                              input logic [st2ptw_pkg::DESC_W-1:0] dd);
        while (!steady && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {dd, ga};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_accepted++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic program_walker(input logic [st2ptw_pkg::SIZE_OFFSET_W-1:0] offset,
                                  input logic [st2ptw_pkg::OUT_ADDR_W-1:0] base);
        cfg_we    <= 1'b1;
        cfg_index <= st2ptw_pkg::REG_SIZE_OFFSET;
        cfg_data  <= {{(st2ptw_pkg::CFG_DATA_W-st2ptw_pkg::SIZE_OFFSET_W){1'b0}}, offset};
        @(posedge clk);
        cfg_index <= st2ptw_pkg::REG_TABLE_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // A whole walk with random content, now and then cut short or replaced by noise.
    task automatic walk_sequence(input int unsigned ias);
        int unsigned pick;
        logic [st2ptw_pkg::DESC_W-1:0] first_desc;
        pick = $urandom_range(99);
        if (pick < 80)
        begin
            issue_item(st2ptw_pkg::OP_START, guest_in_range(ias), random_word());
            if (pick >= 5)
            begin
                first_desc = random_descriptor();
                issue_item(st2ptw_pkg::OP_DESC,
                           st2ptw_pkg::GUEST_ADDR_W'(random_word()), first_desc);
                if (first_desc[1:0] == 2'b11 && $urandom_range(9) != 0)
                    issue_item(st2ptw_pkg::OP_DESC,
                               st2ptw_pkg::GUEST_ADDR_W'(random_word()), random_descriptor());
            end
        end
        else
        begin
            issue_item(1'($urandom_range(1)), st2ptw_pkg::GUEST_ADDR_W'(random_word()),
                       random_word());
        end
    endtask

    initial
    begin
        logic [st2ptw_pkg::SIZE_OFFSET_W-1:0] offset;
        logic [st2ptw_pkg::OUT_ADDR_W-1:0]    base;
        int                                   target;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= st2ptw_pkg::REG_SIZE_OFFSET;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= st2ptw_pkg::OP_START;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walks under the reset settings, a 32-bit input size.
        issue_item(st2ptw_pkg::OP_DESC, '0, 64'h3);
        issue_item(st2ptw_pkg::OP_START, '0, '0);
        issue_item(st2ptw_pkg::OP_DESC, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        issue_item(st2ptw_pkg::OP_START, 56'hFFFF_FFFF, '0);
        issue_item(st2ptw_pkg::OP_DESC, '0, 64'hFFFF_FFFF_FFFF_FFFD);
        issue_item(st2ptw_pkg::OP_START, 56'hFF_FFFF_FFFF_FFFF, '1);
        issue_item(st2ptw_pkg::OP_DESC, '0, '1);
        issue_item(st2ptw_pkg::OP_START, 56'h1_0000_0000, '0);
        issue_item(st2ptw_pkg::OP_START, 56'hDEAD_B000, '0);
        issue_item(st2ptw_pkg::OP_DESC, '0, '1);
        issue_item(st2ptw_pkg::OP_DESC, '0, '1);
        issue_item(st2ptw_pkg::OP_START, 56'h1234_5000, '0);
        issue_item(st2ptw_pkg::OP_DESC, '0, 64'h0000_ABCD_EF01_2003);
        issue_item(st2ptw_pkg::OP_DESC, '0, 64'h0);
        issue_item(st2ptw_pkg::OP_START, 56'h7FFF_F000, '0);
        issue_item(st2ptw_pkg::OP_DESC, '0, 64'h8000_0000_0000_0003);
        issue_item(st2ptw_pkg::OP_DESC, '0, 64'hFFFF_FFFF_FFFF_FFF1);
        issue_item(st2ptw_pkg::OP_START, 56'h0020_0000, '0);
        issue_item(st2ptw_pkg::OP_DESC, '0, '1);
        issue_item(st2ptw_pkg::OP_START, 56'h0040_1000, '0);
        issue_item(st2ptw_pkg::OP_DESC, '0, 64'h5);
        issue_item(st2ptw_pkg::OP_START, 56'h3000, '0);
        issue_item(st2ptw_pkg::OP_DESC, '0, '1);
        issue_item(st2ptw_pkg::OP_START, 56'h80_0000_0000_0000, '0);
        issue_item(st2ptw_pkg::OP_DESC, '0, 64'h3);
        wait_for_results();

        for (int phase = 0; phase < 10; phase++)
        begin
            base = st2ptw_pkg::OUT_ADDR_W'(random_word());
            case (phase)
                0:
                begin
                    offset = 6'd25;
                    base = '1;
                end
                1:
                begin
                    offset = 6'd42;
                    base = '0;
                end
                2: offset = 6'd8;
                3: offset = 6'd0;
                4:
                begin
                    offset = 6'd46;
                    base = '1;
                end
                5: offset = 6'd43;
                6: offset = 6'd63;
                7: offset = 6'd50;
                default: offset = st2ptw_pkg::SIZE_OFFSET_W'($urandom_range(42, 25));
            endcase
            program_walker(offset, base);
            steady = (phase == 2);
            target = items_accepted + 40;
            while (items_accepted < target)
                walk_sequence(64 - offset);
            wait_for_results();
        end
        steady = 1'b0;

        repeat (8) @(posedge clk);
        $display("Covered %0d items over %0d register settings,", items_accepted,
                 settings_used + 1);
        $display("size offsets 0 to 63, bases 0 to all ones.");
        $display("Checked %0d result items: %0d leaves and %0d translation faults.",
                 results_checked, leaves_seen, faults_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS stage2_page_table_walker");
        else
            $display("FAIL stage2_page_table_walker");
        $finish;
    end

endmodule
